// File: rtl/core/pdr_pkg.sv
package pdr_pkg;

	// Request and response words.
	typedef struct packed {
		logic               req_type;
		logic signed [15:0] velocity;
		logic signed [15:0] turn_rate;
		logic        [15:0] time_step;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [15:0] heading;
	} rsp_t;

	// Request kinds.
	localparam logic REQ_ADVANCE = 1'b0;
	localparam logic REQ_CLEAR   = 1'b1;

	// Operand selection of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_OM   = 3'd1,
		MUL_COS  = 3'd2,
		MUL_SIN  = 3'd3,
		MUL_VEL  = 3'd4
	} mul_sel_t;

	localparam int ATAN_IDX_W = 5;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                  load;
		logic                  rot;
		logic [ATAN_IDX_W-1:0] iter;
		mul_sel_t              mul_sel;
		logic                  cap_dh;
		logic                  cap_dx;
		logic                  cap_dy;
		logic                  commit;
		logic                  clear;
	} cmd_t;

	// CORDIC constants: gain-compensated start in Q1.30, angles in Q3.29.
	localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
	localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
	localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;

	// Heading limits in Q3.13, held at the width of the unwrapped sum.
	localparam logic signed [18:0] PI_Q13     = 19'sd25736;
	localparam logic signed [18:0] TWO_PI_Q13 = 19'sd51472;

	function automatic logic signed [31:0] atan_q29(input logic [ATAN_IDX_W-1:0] idx);
		logic signed [31:0] v;
		case (idx)
			5'd0:    v = 32'sd421657428;
			5'd1:    v = 32'sd248918915;
			5'd2:    v = 32'sd131521918;
			5'd3:    v = 32'sd66762579;
			5'd4:    v = 32'sd33510843;
			5'd5:    v = 32'sd16771758;
			5'd6:    v = 32'sd8387925;
			5'd7:    v = 32'sd4194219;
			5'd8:    v = 32'sd2097141;
			5'd9:    v = 32'sd1048575;
			5'd10:   v = 32'sd524288;
			5'd11:   v = 32'sd262144;
			5'd12:   v = 32'sd131072;
			5'd13:   v = 32'sd65536;
			5'd14:   v = 32'sd32768;
			5'd15:   v = 32'sd16384;
			5'd16:   v = 32'sd8192;
			5'd17:   v = 32'sd4096;
			5'd18:   v = 32'sd2048;
			5'd19:   v = 32'sd1024;
			5'd20:   v = 32'sd512;
			5'd21:   v = 32'sd256;
			5'd22:   v = 32'sd128;
			5'd23:   v = 32'sd64;
			default: v = 32'sd0;
		endcase
		return v;
	endfunction

endpackage

// File: rtl/core/pdr_ctrl.sv
module pdr_ctrl #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  logic           req_type,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output pdr_pkg::cmd_t  cmd
);

	localparam int ITW = $clog2(CORDIC_ITERATIONS);
	localparam logic [ITW-1:0] LAST_ITER = ITW'(CORDIC_ITERATIONS - 1);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_MOM  = 10'b00_0000_0010,
		ST_ROT  = 10'b00_0000_0100,
		ST_MC   = 10'b00_0000_1000,
		ST_MCV  = 10'b00_0001_0000,
		ST_MS   = 10'b00_0010_0000,
		ST_MSV  = 10'b00_0100_0000,
		ST_DY   = 10'b00_1000_0000,
		ST_UPD  = 10'b01_0000_0000,
		ST_CLR  = 10'b10_0000_0000
	} state_t;

	state_t         state_q, state_d;
	logic [ITW-1:0] cnt_q, cnt_d;
	logic           rsp_valid_q;
	logic           rsp_set;
	logic           out_free;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		cnt_d     = cnt_q;
		req_ready = 1'b0;
		rsp_set   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = (req_type == pdr_pkg::REQ_CLEAR) ? ST_CLR : ST_MOM;
				end
			end
			ST_MOM: begin
				cmd.mul_sel = pdr_pkg::MUL_OM;
				cnt_d       = '0;
				state_d     = ST_ROT;
			end
			ST_ROT: begin
				cmd.rot  = 1'b1;
				cmd.iter = pdr_pkg::ATAN_IDX_W'(cnt_q);
				if (cnt_q == LAST_ITER) begin
					state_d = ST_MC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MC: begin
				cmd.mul_sel = pdr_pkg::MUL_COS;
				cmd.cap_dh  = 1'b1;
				state_d     = ST_MCV;
			end
			ST_MCV: begin
				cmd.mul_sel = pdr_pkg::MUL_VEL;
				state_d     = ST_MS;
			end
			ST_MS: begin
				cmd.mul_sel = pdr_pkg::MUL_SIN;
				cmd.cap_dx  = 1'b1;
				state_d     = ST_MSV;
			end
			ST_MSV: begin
				cmd.mul_sel = pdr_pkg::MUL_VEL;
				state_d     = ST_DY;
			end
			ST_DY: begin
				cmd.cap_dy = 1'b1;
				state_d    = ST_UPD;
			end
			ST_UPD: begin
				// The pose moves only when the response register can take the word.
				if (out_free) begin
					cmd.commit = 1'b1;
					rsp_set    = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_CLR: begin
				if (out_free) begin
					cmd.clear = 1'b1;
					rsp_set   = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/core/pdr_dpath.sv
module pdr_dpath (
	input  logic          clk,
	input  logic          arst_n,
	input  pdr_pkg::cmd_t cmd,
	input  pdr_pkg::req_t req,
	output pdr_pkg::rsp_t rsp
);

	localparam logic signed [65:0] RND38 = 66'sd1 <<< 37;
	localparam logic signed [65:0] RND15 = 66'sd1 <<< 14;
	localparam logic signed [18:0] TWO_PI_Q13_W = pdr_pkg::TWO_PI_Q13;

	// Captured request fields.
	logic signed [15:0] vel_q;
	logic signed [15:0] om_q;
	logic        [15:0] dt_q;

	// CORDIC state: x and y in Q1.30, residual angle in Q3.29.
	logic signed [33:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic               flip_q;

	logic signed [65:0] prod_q;
	logic signed [17:0] dh_q;
	logic signed [27:0] dx_q, dy_q;

	logic signed [31:0] pos_x_q, pos_y_q;
	logic signed [15:0] head_q;
	pdr_pkg::rsp_t      rsp_q;

	logic signed [31:0] z0;
	logic signed [33:0] xs, ys;
	logic signed [31:0] atan_v;
	logic signed [33:0] cos_v, sin_v;
	logic signed [48:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [65:0] mul_p;
	logic signed [65:0] rnd38, rnd15;
	logic signed [33:0] sum_x, sum_y;
	logic signed [31:0] nx, ny;
	logic signed [18:0] hs, hm1, hm2, hp1, hp2, hw;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
			r = v[31:0];
		end else if (v[33]) begin
			r = {1'b1, {31{1'b0}}};
		end else begin
			r = {1'b0, {31{1'b1}}};
		end
		return r;
	endfunction

	assign z0 = {head_q, 16'b0};

	assign xs     = cx_q >>> cmd.iter;
	assign ys     = cy_q >>> cmd.iter;
	assign atan_v = pdr_pkg::atan_q29(cmd.iter);

	// Undo the half-turn fold taken when the angle was brought into range.
	assign cos_v = flip_q ? -cx_q : cx_q;
	assign sin_v = flip_q ? -cy_q : cy_q;

	always_comb begin
		case (cmd.mul_sel)
			pdr_pkg::MUL_OM: begin
				mul_a = 49'(om_q);
				mul_b = $signed({1'b0, dt_q});
			end
			pdr_pkg::MUL_COS: begin
				mul_a = 49'(cos_v);
				mul_b = $signed({1'b0, dt_q});
			end
			pdr_pkg::MUL_SIN: begin
				mul_a = 49'(sin_v);
				mul_b = $signed({1'b0, dt_q});
			end
			pdr_pkg::MUL_VEL: begin
				mul_a = prod_q[48:0];
				mul_b = 17'(vel_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign rnd38 = prod_q + RND38;
	assign rnd15 = prod_q + RND15;

	assign sum_x = 34'(pos_x_q) + 34'(dx_q);
	assign sum_y = 34'(pos_y_q) + 34'(dy_q);
	assign nx    = sat32(sum_x);
	assign ny    = sat32(sum_y);

	// Heading wrap: the step is bounded so two corrections of a full turn suffice.
	assign hs  = 19'(head_q) + 19'(dh_q);
	assign hm1 = hs - TWO_PI_Q13_W;
	assign hm2 = hm1 - TWO_PI_Q13_W;
	assign hp1 = hs + TWO_PI_Q13_W;
	assign hp2 = hp1 + TWO_PI_Q13_W;

	always_comb begin
		if (hs > pdr_pkg::PI_Q13) begin
			hw = (hm1 > pdr_pkg::PI_Q13) ? hm2 : hm1;
		end else if (hs <= -pdr_pkg::PI_Q13) begin
			hw = (hp1 <= -pdr_pkg::PI_Q13) ? hp2 : hp1;
		end else begin
			hw = hs;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			vel_q <= req.velocity;
			om_q  <= req.turn_rate;
			dt_q  <= req.time_step;
			cx_q  <= pdr_pkg::CORDIC_K;
			cy_q  <= '0;
			if (z0 > pdr_pkg::HALF_PI_Q29) begin
				cz_q   <= z0 - pdr_pkg::PI_Q29;
				flip_q <= 1'b1;
			end else if (z0 < -pdr_pkg::HALF_PI_Q29) begin
				cz_q   <= z0 + pdr_pkg::PI_Q29;
				flip_q <= 1'b1;
			end else begin
				cz_q   <= z0;
				flip_q <= 1'b0;
			end
		end else if (cmd.rot) begin
			if (!cz_q[31]) begin
				cx_q <= cx_q - ys;
				cy_q <= cy_q + xs;
				cz_q <= cz_q - atan_v;
			end else begin
				cx_q <= cx_q + ys;
				cy_q <= cy_q - xs;
				cz_q <= cz_q + atan_v;
			end
		end
		if (cmd.mul_sel != pdr_pkg::MUL_NONE) begin
			prod_q <= mul_p;
		end
		if (cmd.cap_dh) begin
			dh_q <= rnd15[32:15];
		end
		if (cmd.cap_dx) begin
			dx_q <= rnd38[65:38];
		end
		if (cmd.cap_dy) begin
			dy_q <= rnd38[65:38];
		end
		if (cmd.commit) begin
			rsp_q.pos_x   <= nx;
			rsp_q.pos_y   <= ny;
			rsp_q.heading <= hw[15:0];
		end else if (cmd.clear) begin
			rsp_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q  <= '0;
		end else if (cmd.commit) begin
			pos_x_q <= nx;
			pos_y_q <= ny;
			head_q  <= hw[15:0];
		end else if (cmd.clear) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			head_q  <= '0;
		end
	end

	assign rsp = rsp_q;

endmodule

// File: rtl/core/pose_dead_reckoning.sv
// An advance word runs through ST_MOM, the CORDIC rotation in ST_ROT, ST_MC,
// ST_MCV, ST_MS, ST_MSV, ST_DY and ST_UPD; a clear word goes through ST_CLR.
// Only one request is in work at a time. The CORDIC rotation is iterative and the
// shared multiplier forms the displacement in four passes.
// A new request is taken while a finished response still waits in the output register.
// Reset (arst_n low) clears the pose to zero and empties the response register.
module pose_dead_reckoning #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  pdr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output pdr_pkg::rsp_t rsp
);

	pdr_pkg::cmd_t cmd;

	pdr_ctrl #(
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_type  (req.req_type),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	pdr_dpath u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// File: rtl/core/pdr_checker.sv
module pdr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input pdr_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input pdr_pkg::rsp_t rsp
);

	// A response stays offered until it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response withdrawn before it was taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp))
		else $error("response word changed while stalled");

	// The block works on one request at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while the previous one is still in work");

	// Every reported heading lies in the half-open interval around zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.heading > -16'sd25736) && (rsp.heading <= 16'sd25736))
		else $error("heading outside the wrapped range");

endmodule

bind pose_dead_reckoning pdr_checker u_pdr_checker (.*);
